// ===== rtl/core/arot_pkg.sv =====
// Shared constants and helpers for the axis-angle rotation matrix block.
// No dependencies.
`timescale 1ns / 1ps
package arot_pkg;

  localparam int ANGLE_W = 16;
  localparam int ZR_W = 34;
  localparam int XY_W = 33;
  localparam int RND_W = 72;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;

  function automatic logic [29:0] atan_turn(input int idx);
    logic [29:0] r;
    case (idx)
      0: r = 30'd536870912;   1: r = 30'd316933406;   2: r = 30'd167458907;
      3: r = 30'd85004756;    4: r = 30'd42667331;    5: r = 30'd21354465;
      6: r = 30'd10679838;    7: r = 30'd5340245;     8: r = 30'd2670163;
      9: r = 30'd1335087;     10: r = 30'd667544;     11: r = 30'd333772;
      12: r = 30'd166886;     13: r = 30'd83443;      14: r = 30'd41722;
      15: r = 30'd20861;      16: r = 30'd10430;      17: r = 30'd5215;
      18: r = 30'd2608;       19: r = 30'd1304;       20: r = 30'd652;
      21: r = 30'd326;        22: r = 30'd163;        23: r = 30'd81;
      24: r = 30'd41;         25: r = 30'd20;         26: r = 30'd10;
      27: r = 30'd5;          28: r = 30'd3;          29: r = 30'd1;
      30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // shift right by n, round half away from zero
  function automatic logic signed [RND_W-1:0] round_shift(
      input logic signed [RND_W-1:0] v, input int n);
    logic [RND_W-1:0] mag;
    logic [RND_W-1:0] half;
    mag = v[RND_W-1] ? RND_W'(-v) : RND_W'(v);
    half = (RND_W'(1) << n) >> 1;
    mag = (mag + half) >> n;
    return v[RND_W-1] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

// ===== rtl/core/arot_cordic_stage.sv =====
// One registered rotation-mode CORDIC stage, carrying the axis alongside.
// Depends on arot_pkg.
`timescale 1ns / 1ps
module arot_cordic_stage #(
  parameter int STAGE = 0,
  parameter int W = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic signed [arot_pkg::XY_W-1:0]   x_i,
  input  logic signed [arot_pkg::XY_W-1:0]   y_i,
  input  logic signed [arot_pkg::ZR_W-1:0]   z_i,
  input  logic                               flip_i,
  input  logic [3*W-1:0]                     axis_i,
  output logic                               valid_o,
  output logic signed [arot_pkg::XY_W-1:0]   x_o,
  output logic signed [arot_pkg::XY_W-1:0]   y_o,
  output logic signed [arot_pkg::ZR_W-1:0]   z_o,
  output logic                               flip_o,
  output logic [3*W-1:0]                     axis_o
);

  localparam logic signed [arot_pkg::ZR_W-1:0] ATAN =
    $signed(arot_pkg::ZR_W'(arot_pkg::atan_turn(STAGE)));

  logic signed [arot_pkg::XY_W-1:0] dx, dy, x_d, y_d;
  logic signed [arot_pkg::ZR_W-1:0] z_d;
  logic                             valid_q;
  logic signed [arot_pkg::XY_W-1:0] x_q, y_q;
  logic signed [arot_pkg::ZR_W-1:0] z_q;
  logic                             flip_q;
  logic [3*W-1:0]                   axis_q;

  always_comb begin
    dx = y_i >>> STAGE;
    dy = x_i >>> STAGE;
    if (!z_i[arot_pkg::ZR_W-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
      flip_q <= flip_i;
      axis_q <= axis_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
  assign flip_o = flip_q;
  assign axis_o = axis_q;

endmodule

// ===== rtl/core/arot_rodrigues.sv =====
// Four-stage Rodrigues product and sum pipeline with saturating output.
// Depends on arot_pkg.
`timescale 1ns / 1ps
module arot_rodrigues #(
  parameter int W = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic signed [arot_pkg::XY_W-1:0] cx_i,
  input  logic signed [arot_pkg::XY_W-1:0] cy_i,
  input  logic                             flip_i,
  input  logic [3*W-1:0]                   axis_i,
  output logic                             valid_o,
  output logic [9*W-1:0]                   entries_o
);

  localparam int F = W - 2;
  localparam int SH = 32 - W;
  localparam int CS_W = F + 2;
  localparam int K_W = F + 2;
  localparam int P_W = 2 * W;
  localparam int Q_W = W + 1;
  localparam int T_W = W + 1;
  localparam int M_W = Q_W + K_W;
  localparam int R_W = W + 3;
  localparam int S_W = W + 4;
  localparam logic signed [CS_W-1:0] ONE = CS_W'(1) << F;
  localparam logic signed [S_W-1:0] MAX_V = S_W'((64'(1) << (W - 1)) - 1);
  localparam logic signed [S_W-1:0] MIN_V = -MAX_V - S_W'(1);

  logic signed [W-1:0] ax, ay, az;
  logic signed [W-1:0] bx, by, bz;
  logic signed [arot_pkg::RND_W-1:0] rc, rs;
  logic signed [CS_W-1:0] c_d, s_d;
  logic signed [P_W-1:0]  pab_d [6];
  logic signed [P_W-1:0]  ps_d [3];

  logic                   v1_q, v2_q, v3_q, v4_q;
  logic signed [CS_W-1:0] c1_q, c2_q, c3_q;
  logic signed [CS_W-1:0] s1_q;
  logic [3*W-1:0]         a1_q;
  logic [K_W-1:0]         k1_q, k2_q;
  logic signed [P_W-1:0]  pab1_q [6];
  logic signed [P_W-1:0]  ps2_q [3];
  logic [Q_W-1:0]         qm2_q [6];
  logic                   qn2_q [6];
  logic                   qn3_q [6];
  logic signed [T_W-1:0]  t3_q [3];
  logic [M_W-1:0]         mk3_q [6];
  logic [9*W-1:0]         out_q;

  logic signed [arot_pkg::RND_W-1:0] rq [6];
  logic signed [arot_pkg::RND_W-1:0] rt [3];
  logic [M_W-1:0]                    mr [6];
  logic signed [R_W-1:0]             tr [6];
  logic signed [S_W-1:0]             sum [9];
  logic [9*W-1:0]                    out_d;

  function automatic logic signed [CS_W-1:0] clamp_one(
      input logic signed [arot_pkg::RND_W-1:0] v);
    logic signed [CS_W-1:0] r;
    if (v > arot_pkg::RND_W'(ONE)) begin
      r = ONE;
    end else if (v < -arot_pkg::RND_W'(ONE)) begin
      r = -ONE;
    end else begin
      r = CS_W'(v);
    end
    return r;
  endfunction

  function automatic logic [W-1:0] sat(input logic signed [S_W-1:0] v);
    logic [W-1:0] r;
    if (v > MAX_V) begin
      r = W'(MAX_V);
    end else if (v < MIN_V) begin
      r = W'(MIN_V);
    end else begin
      r = W'(v);
    end
    return r;
  endfunction

  // stage 1: sine/cosine rounding, axis products
  always_comb begin
    ax = $signed(axis_i[W-1:0]);
    ay = $signed(axis_i[2*W-1:W]);
    az = $signed(axis_i[3*W-1:2*W]);
    rc = arot_pkg::round_shift(arot_pkg::RND_W'(flip_i ? -cx_i : cx_i), SH);
    rs = arot_pkg::round_shift(arot_pkg::RND_W'(flip_i ? -cy_i : cy_i), SH);
    c_d = clamp_one(rc);
    s_d = clamp_one(rs);
    pab_d[0] = P_W'(ax * ax);
    pab_d[1] = P_W'(ay * ay);
    pab_d[2] = P_W'(az * az);
    pab_d[3] = P_W'(ax * ay);
    pab_d[4] = P_W'(ax * az);
    pab_d[5] = P_W'(ay * az);
  end

  // stage 2 to 4 combinational parts
  always_comb begin
    bx = $signed(a1_q[W-1:0]);
    by = $signed(a1_q[2*W-1:W]);
    bz = $signed(a1_q[3*W-1:2*W]);
    ps_d[0] = P_W'(bx * s1_q);
    ps_d[1] = P_W'(by * s1_q);
    ps_d[2] = P_W'(bz * s1_q);
    for (int j = 0; j < 6; j++) begin
      rq[j] = arot_pkg::round_shift(arot_pkg::RND_W'(pab1_q[j]), F);
      mr[j] = (mk3_q[j] + (M_W'(1) << (F - 1))) >> F;
      tr[j] = qn3_q[j] ? -$signed(R_W'(mr[j])) : $signed(R_W'(mr[j]));
    end
    for (int j = 0; j < 3; j++) begin
      rt[j] = arot_pkg::round_shift(arot_pkg::RND_W'(ps2_q[j]), F);
    end
    sum[0] = S_W'(tr[0]) + S_W'(c3_q);
    sum[1] = S_W'(tr[3]) - S_W'(t3_q[2]);
    sum[2] = S_W'(tr[4]) + S_W'(t3_q[1]);
    sum[3] = S_W'(tr[3]) + S_W'(t3_q[2]);
    sum[4] = S_W'(tr[1]) + S_W'(c3_q);
    sum[5] = S_W'(tr[5]) - S_W'(t3_q[0]);
    sum[6] = S_W'(tr[4]) - S_W'(t3_q[1]);
    sum[7] = S_W'(tr[5]) + S_W'(t3_q[0]);
    sum[8] = S_W'(tr[2]) + S_W'(c3_q);
    for (int j = 0; j < 9; j++) begin
      out_d[j*W +: W] = sat(sum[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q <= c_d;
      s1_q <= s_d;
      a1_q <= axis_i;
      k1_q <= K_W'(ONE - c_d);
      pab1_q <= pab_d;
      c2_q <= c1_q;
      k2_q <= k1_q;
      ps2_q <= ps_d;
      for (int j = 0; j < 6; j++) begin
        qn2_q[j] <= rq[j][arot_pkg::RND_W-1];
        qm2_q[j] <= rq[j][arot_pkg::RND_W-1] ? Q_W'(-rq[j]) : Q_W'(rq[j]);
        mk3_q[j] <= M_W'(qm2_q[j] * k2_q);
      end
      for (int j = 0; j < 3; j++) begin
        t3_q[j] <= T_W'(rt[j]);
      end
      c3_q <= c2_q;
      qn3_q <= qn2_q;
      out_q <= out_d;
    end
  end

  assign valid_o = v4_q;
  assign entries_o = out_q;

endmodule

// ===== rtl/core/axis_angle_rotation_matrix.sv =====
// Top level: angle fold, CORDIC stage chain, Rodrigues pipeline.
// Depends on arot_pkg, arot_cordic_stage, arot_rodrigues.
//
//   channel  direction  payload
//   s_axis   in         turn_angle, axis_x, axis_y, axis_z
//   m_axis   out        nine matrix entries, row-major
//
// The pipeline has one fold register, one register per CORDIC stage and four
// product/sum registers. One transaction per cycle while m_axis is not stalled.
// Reset clears only the valid bits. A stall on m_axis freezes the whole
// pipeline; s_axis_tready drops only while the output holds an untaken result.
`timescale 1ns / 1ps
module axis_angle_rotation_matrix #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int CORDIC_STAGES = 16,
  localparam int W = SAMPLE_WIDTH,
  localparam int IN_W = ((arot_pkg::ANGLE_W + 3 * W + 7) / 8) * 8,
  localparam int OUT_W = ((9 * W + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // turn_angle[15:0], axis_x, axis_y, axis_z, zero fill
  input  logic [IN_W-1:0]     s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // m_row0_col0 .. m_row2_col2 row-major, zero fill
  output logic [OUT_W-1:0]    m_axis_tdata
);

  localparam int N = CORDIC_STAGES;

  logic en;
  logic                             v_q [N+1];
  logic signed [arot_pkg::XY_W-1:0] x_q [N+1];
  logic signed [arot_pkg::XY_W-1:0] y_q [N+1];
  logic signed [arot_pkg::ZR_W-1:0] z_q [N+1];
  logic                             f_q [N+1];
  logic [3*W-1:0]                   a_q [N+1];
  logic [arot_pkg::ANGLE_W-1:0]     ang;
  logic                             flip_d;
  logic [arot_pkg::ANGLE_W-1:0]     ang_f;
  logic                             out_valid;
  logic [9*W-1:0]                   entries;

  assign en = !out_valid || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    ang = s_axis_tdata[arot_pkg::ANGLE_W-1:0];
    flip_d = ang[15] ^ ang[14];
    ang_f = {ang[15] ^ flip_d, ang[14:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q[0] <= arot_pkg::CORDIC_GAIN;
      y_q[0] <= '0;
      z_q[0] <= arot_pkg::ZR_W'($signed({ang_f, 16'h0000}));
      f_q[0] <= flip_d;
      a_q[0] <= s_axis_tdata[arot_pkg::ANGLE_W +: 3*W];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    arot_cordic_stage #(.STAGE(i), .W(W)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v_q[i]),
      .x_i     (x_q[i]),
      .y_i     (y_q[i]),
      .z_i     (z_q[i]),
      .flip_i  (f_q[i]),
      .axis_i  (a_q[i]),
      .valid_o (v_q[i+1]),
      .x_o     (x_q[i+1]),
      .y_o     (y_q[i+1]),
      .z_o     (z_q[i+1]),
      .flip_o  (f_q[i+1]),
      .axis_o  (a_q[i+1])
    );
  end

  arot_rodrigues #(.W(W)) u_rod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (v_q[N]),
    .cx_i      (x_q[N]),
    .cy_i      (y_q[N]),
    .flip_i    (f_q[N]),
    .axis_i    (a_q[N]),
    .valid_o   (out_valid),
    .entries_o (entries)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = OUT_W'(entries);

endmodule

// ===== rtl/core/arot_checker.sv =====
// Port-level checks for axis_angle_rotation_matrix, attached by bind.
// No dependencies.
`timescale 1ns / 1ps
module arot_checker #(
  parameter int OUT_W = 144
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
      s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output backpressure");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output changed");

endmodule

bind axis_angle_rotation_matrix arot_checker #(.OUT_W(OUT_W)) u_arot_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/axis_angle_rotation_matrix_tb.sv =====
// Testbench for axis_angle_rotation_matrix: drives angle/axis transactions, predicts the
// nine fixed-point Rodrigues matrix entries and checks every output transaction in order.
// Depends on arot_pkg and the axis_angle_rotation_matrix RTL.
`timescale 1ns / 1ps
module axis_angle_rotation_matrix_tb;

  localparam int FRAC = 14;
  localparam int IN_BITS = 64;
  localparam int OUT_BITS = 144;
  localparam int PIPE_LAT = 21;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // turn_angle, axis_x, axis_y, axis_z
  logic [IN_BITS-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // m_row0_col0 .. m_row2_col2 row-major
  logic [OUT_BITS-1:0] m_axis_tdata;

  logic [OUT_BITS-1:0] matrix_q[$];
  int                  errors;
  int                  sent_count;
  int                  matrix_count;
  int                  holdoff_cycles;
  int                  stall_left;
  bit                  smooth_flow;

  axis_angle_rotation_matrix u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic longint rnd_drop(longint v, int n);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << (n - 1))) >>> n;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint scaled_product(longint a, longint b, longint k);
    longint q;
    longint m;
    q = rnd_drop(a * b, FRAC);
    m = ((q < 0) ? -q : q) * k;
    m = (m + (longint'(1) << (FRAC - 1))) >>> FRAC;
    return (q < 0) ? -m : m;
  endfunction

  function automatic logic [15:0] sat16(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic logic [OUT_BITS-1:0] rotation_entries(logic [15:0] turn,
      logic signed [15:0] ux, logic signed [15:0] uy, logic signed [15:0] uz);
    logic [31:0] ang;
    logic        flip;
    longint      zr, cx, cy, dx, dy, c, s, k, x, y, z, xs, ys, zs, xy, xz, yz;
    ang = {turn, 16'h0000};
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (flip) ang[31] = ~ang[31];
    zr = longint'($signed(ang));
    cx = 652032874;
    cy = 0;
    for (int i = 0; i < 16; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (zr >= 0) begin
        cx -= dx; cy += dy; zr -= longint'(arot_pkg::atan_turn(i));
      end else begin
        cx += dx; cy -= dy; zr += longint'(arot_pkg::atan_turn(i));
      end
    end
    if (flip) begin
      cx = -cx; cy = -cy;
    end
    c = rnd_drop(cx, 30 - FRAC);
    s = rnd_drop(cy, 30 - FRAC);
    if (c > 16384) c = 16384;
    if (c < -16384) c = -16384;
    if (s > 16384) s = 16384;
    if (s < -16384) s = -16384;
    k = 16384 - c;
    x = longint'(ux); y = longint'(uy); z = longint'(uz);
    xs = rnd_drop(x * s, FRAC);
    ys = rnd_drop(y * s, FRAC);
    zs = rnd_drop(z * s, FRAC);
    xy = scaled_product(x, y, k);
    xz = scaled_product(x, z, k);
    yz = scaled_product(y, z, k);
    return {sat16(scaled_product(z, z, k) + c), sat16(yz + xs), sat16(xz - ys),
            sat16(yz - xs), sat16(scaled_product(y, y, k) + c), sat16(xy + zs),
            sat16(xz + ys), sat16(xy - zs), sat16(scaled_product(x, x, k) + c)};
  endfunction

  task automatic send_rotation(logic [15:0] turn, logic [15:0] ux, logic [15:0] uy,
      logic [15:0] uz, int gap);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {uz, uy, ux, turn};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    matrix_q.push_back(rotation_entries(turn, ux, uy, uz));
    sent_count++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (smooth_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_axis();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 16'($signed($urandom_range(0, 32768)) - 16384);
    if (r < 8) return 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h4000;
      3: return 16'hc000;
      default: return 16'h0000;
    endcase
  endfunction

  task automatic test_directed();
    logic [15:0] angles[12] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'hffff,
                                16'h3fff, 16'h4001, 16'h7fff, 16'h8001, 16'hbfff,
                                16'hc001, 16'h2000};
    foreach (angles[i]) send_rotation(angles[i], 16'h4000, 16'h0000, 16'h0000, pick_gap());
    send_rotation(16'h2000, 16'h0000, 16'h4000, 16'h0000, 0);
    send_rotation(16'h6000, 16'h0000, 16'h0000, 16'h4000, 0);
    send_rotation(16'h5555, 16'h24f3, 16'h24f3, 16'h24f3, 1);
    send_rotation(16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 0);
    send_rotation(16'h8000, 16'h8000, 16'h8000, 16'h8000, 2);
    send_rotation(16'h4000, 16'h8000, 16'h7fff, 16'h8000, 0);
    send_rotation(16'hc000, 16'h7fff, 16'h8000, 16'h7fff, 0);
    send_rotation(16'hffff, 16'hffff, 16'hffff, 16'hffff, 0);
    send_rotation(16'h1234, 16'hc000, 16'hc000, 16'h0000, 3);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      smooth_flow = (i % 200) >= 150;
      send_rotation(16'($urandom_range(0, 65535)), pick_axis(), pick_axis(), pick_axis(),
                    pick_gap());
    end
    smooth_flow = 1'b0;
  endtask

  task automatic test_backpressure();
    holdoff_cycles = 60;
    for (int i = 0; i < 80; i++)
      send_rotation(16'($urandom_range(0, 65535)), pick_axis(), pick_axis(), pick_axis(), 0);
  endtask

  // receiver: random stalls, forced hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (holdoff_cycles > 0) begin
      m_axis_tready  <= 1'b0;
      holdoff_cycles <= holdoff_cycles - 1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (!smooth_flow && $urandom_range(0, 99) < 25) begin
      m_axis_tready <= 1'b0;
      stall_left    <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (matrix_q.size() == 0) begin
        $display("%0t: unexpected matrix %h", $time, m_axis_tdata);
        errors++;
      end else begin
        logic [OUT_BITS-1:0] want;
        want = matrix_q.pop_front();
        for (int e = 0; e < 9; e++)
          if (m_axis_tdata[e*16 +: 16] !== want[e*16 +: 16]) begin
            $display("%0t: entry row%0d col%0d expected %0d actual %0d", $time, e / 3,
                     e % 3, $signed(want[e*16 +: 16]), $signed(m_axis_tdata[e*16 +: 16]));
            errors++;
          end
        matrix_count++;
      end
    end
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    errors = 0;
    sent_count = 0;
    matrix_count = 0;
    holdoff_cycles = 0;
    smooth_flow = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(850);
    s_axis_tvalid <= 1'b0;
    while (matrix_q.size() > 0) @(posedge clk_i);
    repeat (PIPE_LAT + 10) @(posedge clk_i);
    $display("Sent %0d rotations, checked %0d matrices under random gaps and stalls",
             sent_count, matrix_count);
    $display("Covered quarter-turn folds, saturating axes and a long output hold-off");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
